[design/mmp_pkg.sv]
// Shared constants, types and modular arithmetic helpers for the 2x2 matrix power unit.
package mmp_pkg;

  localparam int unsigned DataW       = 30;
  localparam int unsigned ExpWidthDef = 63;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned MulSteps    = DataW;
  localparam int unsigned StepCntW    = $clog2(MulSteps);

  localparam logic [DataW-1:0] Modulus = 30'd1000000007;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegBaseR0C0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBaseR0C1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBaseR1C0 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBaseR1C1 = 3'd3;

  // m[row][col]
  typedef logic [1:0][1:0][DataW-1:0] mat_t;

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StMul,
    StDone
  } state_e;

  // Values below 2^30 are below 2*Modulus, so one conditional subtract suffices.
  function automatic logic [DataW-1:0] mod_reduce1(input logic [DataW-1:0] v);
    return (v >= Modulus) ? (v - Modulus) : v;
  endfunction

  function automatic logic [DataW-1:0] mod_add(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, Modulus}) begin
      s = s - {1'b0, Modulus};
    end
    return s[DataW-1:0];
  endfunction

  // One MSB-first step of a shift-and-add modular product: (2r + bit*a) mod p.
  // Sum stays below 3p, so at most one of p or 2p is taken off.
  function automatic logic [DataW-1:0] mod_step(input logic [DataW-1:0] r,
                                                input logic [DataW-1:0] a,
                                                input logic             b);
    logic [DataW+1:0] t;
    logic [DataW+1:0] p1;
    logic [DataW+1:0] p2;
    p1 = {2'b00, Modulus};
    p2 = {1'b0, Modulus, 1'b0};
    t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    if (t >= p2) begin
      t = t - p2;
    end else if (t >= p1) begin
      t = t - p1;
    end
    return t[DataW-1:0];
  endfunction

endpackage

[design/mmp_mul_lane.sv]
// Bit-serial modular multiplier lane: one multiplier bit per cycle while step_i is high, MSB first.
module mmp_mul_lane (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      step_i,
  input  logic [mmp_pkg::DataW-1:0] a_i,
  input  logic [mmp_pkg::DataW-1:0] b_i,
  output logic [mmp_pkg::DataW-1:0] prod_o
);
  import mmp_pkg::*;

  logic [DataW-1:0] r_q, r_d;
  logic [DataW-1:0] b_q, b_d;

  always_comb begin
    r_d = r_q;
    b_d = b_q;
    if (load_i) begin
      r_d = '0;
      b_d = b_i;
    end else if (step_i) begin
      r_d = mod_step(r_q, a_i, b_q[DataW-1]);
      b_d = {b_q[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
  end

  assign prod_o = r_q;

endmodule

[design/mmp_matmul.sv]
// 2x2 modular matrix product z = x*y on eight bit-serial lanes sharing one step counter.
module mmp_matmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mmp_pkg::mat_t x_i,
  input  mmp_pkg::mat_t y_i,
  output logic          done_o,
  output mmp_pkg::mat_t z_o
);
  import mmp_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [1:0][1:0][1:0][DataW-1:0] prod;  // [i][j][k] = x[i][j]*y[j][k]

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == StepCntW'(MulSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_row
    for (genvar j = 0; j < 2; j++) begin : g_inner
      for (genvar k = 0; k < 2; k++) begin : g_col
        mmp_mul_lane u_lane (
          .clk_i  (clk_i),
          .load_i (start_i),
          .step_i (busy_q),
          .a_i    (x_i[i][j]),
          .b_i    (y_i[j][k]),
          .prod_o (prod[i][j][k])
        );
      end
    end
    for (genvar k = 0; k < 2; k++) begin : g_sum
      assign z_o[i][k] = mod_add(prod[i][0][k], prod[i][1][k]);
    end
  end

  assign done_o = done_q;

endmodule

[design/modular_matrix_power_2x2_unit.sv]
// Top level of the 2x2 modular matrix power unit.
//
// Raises the configured base matrix to the power given by each input
// exponent, all arithmetic modulo 1000000007, by square-and-multiply over the
// exponent bits from the LSB up. Exponent zero returns the identity; with the
// reset base [[0,1],[1,1]] res_r1c0 is the Fibonacci number F(k). Base
// registers written with values of 1000000007 or above are reduced on use.
// One exponent is worked on at a time: each exponent bit runs two matrix
// products in parallel (acc*sq and sq*sq), each on eight bit-serial lanes
// that take one multiplier bit per cycle while a product runs. An item runs
// one such pair of products for each exponent bit up to the highest set one,
// and none for an exponent of zero. The result sits in an output register,
// so a new exponent is taken while the previous result waits for its
// transfer. Configuration writes take effect at once and must only happen
// while the unit is idle.
module modular_matrix_power_2x2_unit #(
  parameter int unsigned EXP_WIDTH = mmp_pkg::ExpWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [mmp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mmp_pkg::DataW-1:0]   cfg_data_i,
  // exponent input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [EXP_WIDTH-1:0]        exponent_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmp_pkg::DataW-1:0]   res_r0c0_o,
  output logic [mmp_pkg::DataW-1:0]   res_r0c1_o,
  output logic [mmp_pkg::DataW-1:0]   res_r1c0_o,
  output logic [mmp_pkg::DataW-1:0]   res_r1c1_o
);
  import mmp_pkg::*;

  // identity matrix, packed [1][1] down to [0][0]
  localparam mat_t AccInit = {DataW'(1), DataW'(0), DataW'(0), DataW'(1)};

  // base matrix registers
  logic [DataW-1:0] base_r0c0_q, base_r0c1_q, base_r1c0_q, base_r1c1_q;

  state_e state_q, state_d;

  logic [EXP_WIDTH-1:0] exp_q;   // remaining exponent bits, LSB next
  mat_t                 acc_q;   // running product
  mat_t                 sq_q;    // base^(2^bit)
  mat_t                 res_q;   // output register
  logic                 out_valid_q;

  mat_t acc_prod, sq_prod;
  logic acc_done, sq_done, mm_done;

  logic in_xfer, exp_zero, mm_start, upd, out_load;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign exp_zero = (exp_q == '0);
  assign mm_done  = acc_done & sq_done;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_r0c0_q <= DataW'(0);
      base_r0c1_q <= DataW'(1);
      base_r1c0_q <= DataW'(1);
      base_r1c1_q <= DataW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBaseR0C0: base_r0c0_q <= cfg_data_i;
        RegBaseR0C1: base_r0c1_q <= cfg_data_i;
        RegBaseR1C0: base_r1c0_q <= cfg_data_i;
        RegBaseR1C1: base_r1c1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_xfer) state_d = StStart;
      StStart: state_d = exp_zero ? StDone : StMul;
      StMul:   if (mm_done) state_d = StStart;
      StDone:  if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    mm_start   = 1'b0;
    upd        = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StStart: mm_start   = !exp_zero;
      StMul:   upd        = mm_done;
      StDone:  out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      exp_q <= exponent_i;
      acc_q <= AccInit;
      sq_q  <= {mod_reduce1(base_r1c1_q), mod_reduce1(base_r1c0_q),
                mod_reduce1(base_r0c1_q), mod_reduce1(base_r0c0_q)};
    end else if (upd) begin
      if (exp_q[0]) begin
        acc_q <= acc_prod;
      end
      sq_q  <= sq_prod;
      exp_q <= exp_q >> 1;
    end
    if (out_load) begin
      res_q <= acc_q;
    end
  end

  // multiply step: acc*sq
  mmp_matmul u_mm_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (acc_q),
    .y_i     (sq_q),
    .done_o  (acc_done),
    .z_o     (acc_prod)
  );

  // square step: sq*sq
  mmp_matmul u_mm_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (sq_q),
    .y_i     (sq_q),
    .done_o  (sq_done),
    .z_o     (sq_prod)
  );

  assign out_valid_o = out_valid_q;
  assign res_r0c0_o  = res_q[0][0];
  assign res_r0c1_o  = res_q[0][1];
  assign res_r1c0_o  = res_q[1][0];
  assign res_r1c1_o  = res_q[1][1];

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the 2x2 modular matrix power unit.
`timescale 1ns / 1ps

module tb_top;
  import mmp_pkg::*;

  localparam int unsigned ExpW       = ExpWidthDef;
  localparam int unsigned CycleLimit = 5_000_000;
  // the tail outlasts one more full-width exponent item
  localparam int unsigned TailCycles = 2100;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 93;
  localparam int unsigned MaxReports = 10;

  localparam bit [63:0] ModP = {34'd0, Modulus};

  // indexes past the last base register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd4;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  localparam logic [DataW-1:0] RegMax  = '1;
  localparam logic [DataW-1:0] PMinus1 = Modulus - DataW'(1);
  localparam logic [DataW-1:0] WrapVal = RegMax - Modulus;  // RegMax reduced once

  localparam logic [ExpW-1:0] ExpMax = '1;
  localparam logic [ExpW-1:0] ExpTop = {1'b1, {(ExpW-1){1'b0}}};

  typedef enum logic {
    RowPower,
    RowWrite
  } row_kind_e;

  typedef enum logic [1:0] {
    RecvAlways,
    RecvCoin,
    RecvLongStall
  } recv_mode_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [DataW-1:0]   data;
    logic [ExpW-1:0]    expo;
    bit                 typed;
    mat_t               want;
  } dir_row_t;

  typedef struct {
    logic [ExpW-1:0] expo;
    mat_t            want;
  } pending_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [DataW-1:0]    cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [ExpW-1:0]     exponent   = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [DataW-1:0]    res_r0c0;
  logic [DataW-1:0]    res_r0c1;
  logic [DataW-1:0]    res_r1c0;
  logic [DataW-1:0]    res_r1c1;

  // what the unit should hold in its base registers
  logic [DataW-1:0]    base_shadow [4];
  pending_t            pending_powers [$];
  dir_row_t            dir_rows [$];

  int unsigned cycle_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned wide_count   = 0;
  int unsigned write_count  = 0;
  int unsigned check_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned unexpected   = 0;
  int unsigned report_count = 0;
  bit          tail_open    = 1'b0;

  recv_mode_e  recv_mode    = RecvAlways;
  int unsigned mode_left    = 0;
  int unsigned hold_left    = 0;

  modular_matrix_power_2x2_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .exponent_i  (exponent),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_r0c0_o  (res_r0c0),
    .res_r0c1_o  (res_r0c1),
    .res_r1c0_o  (res_r1c0),
    .res_r1c1_o  (res_r1c1)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic mat_t mk(input logic [DataW-1:0] d00, input logic [DataW-1:0] d01,
                              input logic [DataW-1:0] d10, input logic [DataW-1:0] d11);
    mat_t m;
    m[0][0] = d00;
    m[0][1] = d01;
    m[1][0] = d10;
    m[1][1] = d11;
    return m;
  endfunction

  // 2x2 product mod p; every entry product and the row sum are reduced
  function automatic mat_t mat_mult(input mat_t x, input mat_t y);
    mat_t      r;
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] p0;
    bit [63:0] p1;
    bit [63:0] s;
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 2; k++) begin
        a  = x[i][0];
        b  = y[0][k];
        p0 = (a * b) % ModP;
        a  = x[i][1];
        b  = y[1][k];
        p1 = (a * b) % ModP;
        s  = (p0 + p1) % ModP;
        r[i][k] = s[DataW-1:0];
      end
    end
    return r;
  endfunction

  // base^expo by square-and-multiply from the LSB; registers reduced on use
  function automatic mat_t matrix_power(input logic [ExpW-1:0] expo);
    mat_t            sq;
    mat_t            acc;
    logic [ExpW-1:0] k;
    sq  = mk(base_shadow[RegBaseR0C0[1:0]] % Modulus, base_shadow[RegBaseR0C1[1:0]] % Modulus,
             base_shadow[RegBaseR1C0[1:0]] % Modulus, base_shadow[RegBaseR1C1[1:0]] % Modulus);
    acc = mk(1, 0, 0, 1);
    k   = expo;
    while (k != 0) begin
      if (k[0]) begin
        acc = mat_mult(acc, sq);
      end
      sq = mat_mult(sq, sq);
      k  = k >> 1;
    end
    return acc;
  endfunction

  function automatic dir_row_t row_power(input logic [ExpW-1:0] expo, input bit typed,
                                         input mat_t want);
    dir_row_t row;
    row.kind  = RowPower;
    row.idx   = '0;
    row.data  = '0;
    row.expo  = expo;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic dir_row_t row_write(input logic [CfgIdxW-1:0] idx,
                                         input logic [DataW-1:0] data);
    dir_row_t row;
    row.kind  = RowWrite;
    row.idx   = idx;
    row.data  = data;
    row.expo  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // All driver tasks start and end just after a falling edge.

  // Drop valid and hold off until every result is back; the unit is idle then.
  task automatic park();
    in_valid = 1'b0;
    while (pending_powers.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    if (idx <= RegBaseR1C1) begin
      base_shadow[idx[1:0]] = data;
    end
    write_count++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Present one exponent, hold it until the transfer, then log what should come back.
  // Valid is left high so a burst can go on at the next falling edge.
  task automatic send(input logic [ExpW-1:0] expo, input bit typed, input mat_t want);
    pending_t p;
    in_valid = 1'b1;
    exponent = expo;
    do @(posedge clk); while (!in_ready);
    p.expo = expo;
    p.want = typed ? want : matrix_power(expo);
    pending_powers.insert(pending_powers.size(), p);
    sent_count++;
    if (expo[ExpW-1:32] != 0) begin
      wide_count++;
    end
    @(negedge clk);
  endtask

  // Result checker: each transfer is matched against the oldest logged exponent.
  always @(posedge clk) begin
    pending_t p;
    mat_t     got;
    if (rst_n && out_valid && out_ready) begin
      got = mk(res_r0c0, res_r0c1, res_r1c0, res_r1c1);
      if (pending_powers.size() == 0) begin
        unexpected++;
        if (report_count < MaxReports) begin
          report_count++;
          $display("unexpected result %0d %0d %0d %0d at cycle %0d",
                   res_r0c0, res_r0c1, res_r1c0, res_r1c1, cycle_count);
        end
      end else begin
        p = pending_powers.pop_front();
        check_count++;
        for (int r = 0; r < 2; r++) begin
          for (int c = 0; c < 2; c++) begin
            if (got[r][c] !== p.want[r][c]) begin
              mismatches++;
              if (report_count < MaxReports) begin
                report_count++;
                $display("mismatch exponent %0d res_r%0dc%0d: expected %0d, got %0d",
                         p.expo, r, c, p.want[r][c], got[r][c]);
              end
            end
          end
        end
      end
    end
  end

  // Receiver: switches between always-ready, coin-flip and long-stall stretches.
  always @(negedge clk) begin
    if (tail_open) begin
      out_ready = 1'b1;
    end else begin
      if (mode_left == 0) begin
        recv_mode = recv_mode_e'($urandom_range(2));
        mode_left = $urandom_range(400, 100);
      end
      mode_left--;
      case (recv_mode)
        RecvAlways: begin
          out_ready = 1'b1;
        end
        RecvCoin: begin
          out_ready = 1'($urandom_range(1));
        end
        default: begin
          if (hold_left == 0) begin
            out_ready = ~out_ready;
            hold_left = out_ready ? $urandom_range(4, 1) : $urandom_range(60, 1);
          end else begin
            hold_left--;
          end
        end
      endcase
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_powers.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [63:0]     r64;
    logic [ExpW-1:0] expo;
    logic [ExpW-1:0] mask;
    logic [DataW-1:0] val;
    int unsigned     burst_left;
    int unsigned     len;
    int unsigned     pick;

    base_shadow[RegBaseR0C0[1:0]] = DataW'(0);
    base_shadow[RegBaseR0C1[1:0]] = DataW'(1);
    base_shadow[RegBaseR1C0[1:0]] = DataW'(1);
    base_shadow[RegBaseR1C1[1:0]] = DataW'(1);

    // Directed rows. With the reset base [[0,1],[1,1]] the power is
    // [[F(k-1),F(k)],[F(k),F(k+1)]], which gives the typed values below.
    add_row(row_power(0, 1, mk(1, 0, 0, 1)));
    add_row(row_power(1, 1, mk(0, 1, 1, 1)));
    add_row(row_power(2, 1, mk(1, 1, 1, 2)));
    add_row(row_power(10, 1, mk(34, 55, 55, 89)));
    add_row(row_power(ExpMax, 0, '0));
    add_row(row_power(ExpTop, 0, '0));
    add_row(row_power(63'h5555_5555_5555_5555, 0, '0));
    add_row(row_power(63'h2AAA_AAAA_AAAA_AAAA, 0, '0));
    // unreduced base: every register at its all-ones value
    add_row(row_write(RegBaseR0C0, RegMax));
    add_row(row_write(RegBaseR0C1, RegMax));
    add_row(row_write(RegBaseR1C0, RegMax));
    add_row(row_write(RegBaseR1C1, RegMax));
    add_row(row_power(0, 1, mk(1, 0, 0, 1)));
    add_row(row_power(1, 1, mk(WrapVal, WrapVal, WrapVal, WrapVal)));
    add_row(row_power(ExpMax, 0, '0));
    // base of all -1: squaring gives 2 everywhere
    add_row(row_write(RegBaseR0C0, PMinus1));
    add_row(row_write(RegBaseR0C1, PMinus1));
    add_row(row_write(RegBaseR1C0, PMinus1));
    add_row(row_write(RegBaseR1C1, PMinus1));
    add_row(row_power(1, 1, mk(PMinus1, PMinus1, PMinus1, PMinus1)));
    add_row(row_power(2, 1, mk(2, 2, 2, 2)));
    add_row(row_power(63'h4000_0000_0000_0001, 0, '0));
    // zero base, plus writes to indexes past the last register
    add_row(row_write(RegBaseR0C0, 0));
    add_row(row_write(RegBaseR0C1, 0));
    add_row(row_write(RegBaseR1C0, 0));
    add_row(row_write(RegBaseR1C1, 0));
    add_row(row_write(RegUnusedLo, RegMax));
    add_row(row_write(RegUnusedHi, 30'h1555_5555));
    add_row(row_power(0, 1, mk(1, 0, 0, 1)));
    add_row(row_power(3, 1, mk(0, 0, 0, 0)));
    // identity base
    add_row(row_write(RegBaseR0C0, 1));
    add_row(row_write(RegBaseR1C1, 1));
    add_row(row_write(RegUnusedHi, RegMax));
    add_row(row_power(ExpMax, 1, mk(1, 0, 0, 1)));
    add_row(row_power(12345, 1, mk(1, 0, 0, 1)));
    // back to the Fibonacci base; the dropped writes must not have landed
    add_row(row_write(RegBaseR0C0, 0));
    add_row(row_write(RegBaseR0C1, 1));
    add_row(row_write(RegBaseR1C0, 1));
    add_row(row_power(1, 1, mk(0, 1, 1, 1)));
    add_row(row_power(90, 0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite) begin
        if (in_valid || pending_powers.size() != 0) begin
          park();
        end
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send(dir_rows[i].expo, dir_rows[i].typed, dir_rows[i].want);
        len = $urandom_range(2);
        if (len != 0) begin
          in_valid = 1'b0;
          repeat (len) @(negedge clk);
        end
      end
    end

    // Random phases, each under its own base setting.
    burst_left = 0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      park();
      for (int idx = 0; idx <= RegBaseR1C1; idx++) begin
        r64 = {$urandom, $urandom};
        case (phase)
          0: val = (idx == RegBaseR0C0) ? DataW'(0) : DataW'(1);   // Fibonacci base
          2: val = r64[DataW-1:0];                                 // full 30-bit range, some unreduced
          3: val = PMinus1;
          4: begin
            pick = $urandom_range(3);
            val  = (pick == 0) ? '0 : (pick == 1) ? DataW'(1) :
                   (pick == 2) ? PMinus1 : RegMax;
          end
          default: val = DataW'($urandom_range(PMinus1, 0));
        endcase
        write_reg(idx[CfgIdxW-1:0], val);
      end
      write_reg(CfgIdxW'($urandom_range(RegUnusedHi, RegUnusedLo)), DataW'($urandom));

      for (int n = 0; n < PhaseItems; n++) begin
        // halfway through a phase the sender waits for the unit to run dry
        if (n == PhaseItems / 2) begin
          park();
        end
        if (burst_left == 0) begin
          in_valid = 1'b0;
          repeat ($urandom_range(40, 1)) @(negedge clk);
          burst_left = $urandom_range(12, 1);
        end
        // mostly short exponents; a few full-width ones since those take longest
        r64  = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 15) begin
          expo = r64[ExpW-1:0];
        end else if (pick < 25) begin
          expo = $urandom_range(3);
        end else begin
          len  = $urandom_range(16, 1);
          mask = '1;
          mask = mask >> (ExpW - len);
          expo = r64[ExpW-1:0] & mask;
        end
        send(expo, 1'b0, '0);
        burst_left--;
      end
    end

    in_valid = 1'b0;
    while (pending_powers.size() != 0) @(negedge clk);
    // keep watching for stray results with the receiver wide open
    tail_open = 1'b1;
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d exponents (%0d wider than 32 bits) over %0d register writes;",
             sent_count, wide_count, write_count);
    $display("checked %0d results: %0d field mismatches, %0d unexpected, %0d cycles.",
             check_count, mismatches, unexpected, cycle_count);
    if (mismatches == 0 && unexpected == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
